FILE: design/vno_pkg.sv
// ============================================================================
// Value noise package
// Shared constants, types and the cosine weight table of the value noise block.
// ============================================================================
package vno_pkg;

    localparam int MaxOct   = 8;
    localparam int LatPer   = 25;
    localparam int CosBits  = 8;
    localparam int CosN     = 1 << CosBits;
    localparam int ModW     = $clog2(LatPer);
    localparam int LatW     = ModW + 1;
    localparam int IdxW     = (MaxOct > 1) ? $clog2(MaxOct) : 1;
    localparam int CntW     = 4;
    localparam int AmpW     = 17;
    localparam int GW       = 32;
    localparam int SmW      = 36;
    localparam int PrW      = SmW + AmpW + 1;
    localparam int CtW      = SmW + AmpW + 1;
    localparam int SumW     = 56;
    localparam int RndSh    = 38;
    localparam int OutW     = 16;
    localparam int Recip    = 65536 / LatPer;
    localparam logic [63:0] PiQ30 = 64'd3373259426;

    localparam logic [31:0] HashMulA = 32'd15731;
    localparam logic [31:0] HashAddA = 32'd789221;
    localparam logic [31:0] HashAddB = 32'd1376312589;
    localparam logic [31:0] HashRow  = 32'd57;

    localparam logic [0:0] RegPers = 1'b0;
    localparam logic [0:0] RegCnt  = 1'b1;

    typedef logic [15:0] t_lut [CosN];

    typedef struct packed {
        logic [ModW-1:0] m;
        logic            z;
        logic [15:0]     f;
    } t_pos;

    typedef struct packed {
        logic                   valid;
        logic signed [SumW-1:0] sum;
        logic [AmpW-1:0]        amp;
        t_pos                   px;
        t_pos                   py;
    } t_item;

    typedef struct packed {
        logic                   valid;
        logic signed [SumW-1:0] sum;
        logic [AmpW-1:0]        amp;
        logic [AmpW-1:0]        amp_nx;
        t_pos                   px;
        t_pos                   py;
        logic [15:0]            wx;
        logic [15:0]            wy;
    } t_side;

    function automatic t_lut build_cos_lut();
        t_lut                lut;
        logic [63:0]         theta;
        logic [63:0]         t2;
        logic [63:0]         term;
        logic [63:0]         hw;
        logic signed [63:0]  c;
        logic signed [63:0]  d;
        int                  kk;
        for (int k = 0; k < CosN; k++) begin
            kk = (k <= CosN / 2) ? k : CosN - k;
            theta = (PiQ30 * 64'(kk)) >> CosBits;
            t2 = (theta * theta) >> 30;
            term = 64'd1 << 30;
            c = 64'sd1 <<< 30;
            for (int j = 1; j <= 10; j++) begin
                term = ((term * t2) >> 30) / 64'((2 * j - 1) * (2 * j));
                if ((j % 2) == 1) begin
                    c = c - $signed(term);
                end else begin
                    c = c + $signed(term);
                end
            end
            d = (64'sd1 <<< 30) - c;
            if (d < 0) begin
                d = 0;
            end
            hw = 64'(d + 64'sd16384) >> 15;
            if (k <= CosN / 2) begin
                lut[k] = hw[15:0];
            end else begin
                lut[k] = 16'(64'd65536 - hw);
            end
        end
        return lut;
    endfunction

    localparam t_lut CosLut = build_cos_lut();

endpackage

FILE: design/value_noise_2d_octaves_top.sv
// ============================================================================
// Fractal 2-D value noise
// Top level: coordinate front end, a chain of octave cells and the output
// rounding stage, with the register port.
// ============================================================================
// One coordinate pair is taken in every cycle in which the output is not
// stalled, and one Q4.12 noise value comes out for each, in order. It passes
// through the front-end registers, the chain of eight octave cells, each a 13-stage
// pipeline (five for the lattice hash multipliers, two for smoothing, four for
// the two blends, two for weighting and summing), and the output register. All
// stages advance together and halt while a result waits on the output.
module value_noise_2d_octaves_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x [31:0], coord_y [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // noise_value [15:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vno_pkg::*;

    logic                    w_en;
    logic [15:0]             r_pers;
    logic [CntW-1:0]         r_cnt;
    logic                    r_fa_valid, r_out_valid;
    logic [15:0]             r_fa_ix, r_fa_iy, r_fa_qx, r_fa_qy;
    logic [15:0]             r_fa_fx, r_fa_fy;
    t_item                   r_fb;
    t_item                   w_chain [MaxOct+1];
    logic [15:0]             w_rx, w_ry;
    logic signed [SumW-1:0]  w_rnd;
    logic signed [SumW-RndSh-1:0] w_v;
    logic [OutW-1:0]         r_out_data;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == RegCnt) ? {28'd0, r_cnt} : {16'd0, r_pers};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pers <= 16'd29491;
            r_cnt  <= CntW'(3);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                RegPers: r_pers <= pwdata[15:0];
                RegCnt:  r_cnt  <= pwdata[CntW-1:0];
                default: ;
            endcase
        end
    end

    assign w_rx = r_fa_ix - 16'(r_fa_qx * 16'(LatPer));
    assign w_ry = r_fa_iy - 16'(r_fa_qy * 16'(LatPer));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_valid <= 1'b0;
            r_fb.valid <= 1'b0;
        end else if (w_en) begin
            r_fa_valid <= s_axis_tvalid;
            r_fb.valid <= r_fa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa_ix <= s_axis_tdata[31:16];
            r_fa_iy <= s_axis_tdata[63:48];
            r_fa_fx <= s_axis_tdata[15:0];
            r_fa_fy <= s_axis_tdata[47:32];
            r_fa_qx <= 16'((32'(s_axis_tdata[31:16]) * 32'(Recip)) >> 16);
            r_fa_qy <= 16'((32'(s_axis_tdata[63:48]) * 32'(Recip)) >> 16);
            r_fb.sum  <= '0;
            r_fb.amp  <= AmpW'(65536);
            r_fb.px.m <= ModW'((w_rx >= 16'(LatPer)) ? w_rx - 16'(LatPer) : w_rx);
            r_fb.py.m <= ModW'((w_ry >= 16'(LatPer)) ? w_ry - 16'(LatPer) : w_ry);
            r_fb.px.z <= (r_fa_ix == 16'd0);
            r_fb.py.z <= (r_fa_iy == 16'd0);
            r_fb.px.f <= r_fa_fx;
            r_fb.py.f <= r_fa_fy;
        end
    end

    assign w_chain[0] = r_fb;

    for (genvar i = 0; i < MaxOct; i++) begin : g_cell
        vno_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (IdxW'(i)),
            .i_cnt   (r_cnt),
            .i_pers  (r_pers),
            .i_in    (w_chain[i]),
            .o_out   (w_chain[i+1])
        );
    end

    assign w_rnd = w_chain[MaxOct].sum + (SumW'(1) <<< (RndSh - 1));
    assign w_v   = (SumW - RndSh)'(w_rnd >>> RndSh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[MaxOct].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_v > (SumW - RndSh)'(32767)) begin
                r_out_data <= 16'h7FFF;
            end else if (w_v < -(SumW - RndSh)'(32768)) begin
                r_out_data <= 16'h8000;
            end else begin
                r_out_data <= w_v[OutW-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: design/vno_hash.sv
// ============================================================================
// Lattice hash pipeline
// Five-stage integer hash that turns one lattice point into a Q1.30 value.
// ============================================================================
module vno_hash (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [vno_pkg::LatW-1:0]  i_lx,
    input  logic signed [vno_pkg::LatW-1:0]  i_ly,
    output logic signed [vno_pkg::GW-1:0]    o_g
);
    import vno_pkg::*;

    logic [31:0] w_h0;
    logic [31:0] r_h1, r_h1d, r_h1dd, r_p, r_q, r_h;
    logic signed [GW-1:0] r_g;

    assign w_h0 = 32'(i_lx) + 32'(i_ly) * HashRow;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1   <= (w_h0 << 13) ^ w_h0;
            r_p    <= r_h1 * r_h1;
            r_h1d  <= r_h1;
            r_q    <= r_p * HashMulA + HashAddA;
            r_h1dd <= r_h1d;
            r_h    <= r_h1dd * r_q + HashAddB;
            r_g    <= $signed(32'h4000_0000) - $signed({1'b0, r_h[30:0]});
        end
    end

    assign o_g = r_g;

endmodule

FILE: design/vno_cell.sv
// ============================================================================
// Octave cell
// Computes one octave of noise, adds it to the running sum if the octave count
// covers its index, and hands the rescaled coordinate and next amplitude on.
// ============================================================================
module vno_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [vno_pkg::IdxW-1:0]   i_idx,
    input  logic [vno_pkg::CntW-1:0]   i_cnt,
    input  logic [15:0]                i_pers,
    input  vno_pkg::t_item             i_in,
    output vno_pkg::t_item             o_out
);
    import vno_pkg::*;

    localparam int SdN = 12;

    t_side                   r_sd [SdN];
    t_side                   n_sd0;
    t_item                   r_out;
    logic signed [LatW-1:0]  w_lx [4];
    logic signed [LatW-1:0]  w_ly [4];
    logic signed [GW-1:0]    w_g [4][4];
    logic signed [SmW-1:0]   r_cor [2][2];
    logic signed [SmW-1:0]   r_sid [2][2];
    logic signed [SmW-1:0]   r_cen [2][2];
    logic signed [SmW-1:0]   r_s [2][2];
    logic signed [PrW-1:0]   r_pa [2];
    logic signed [PrW-1:0]   r_pb [2];
    logic signed [SmW-1:0]   r_r [2];
    logic signed [PrW-1:0]   r_qa;
    logic signed [PrW-1:0]   r_qb;
    logic signed [SmW-1:0]   r_rr;
    logic signed [CtW-1:0]   r_ct;
    logic                    w_act;

    function automatic void lat_coords(input t_pos p, output logic signed [LatW-1:0] l [4]);
        logic [LatW:0] s2;
        s2 = (LatW + 1)'(p.m) + (LatW + 1)'(2);
        if (p.z) begin
            l[0] = '1;
        end else if (p.m == '0) begin
            l[0] = LatW'(LatPer - 1);
        end else begin
            l[0] = LatW'(p.m) - LatW'(1);
        end
        l[1] = LatW'(p.m);
        l[2] = (p.m == ModW'(LatPer - 1)) ? '0 : LatW'(p.m) + LatW'(1);
        l[3] = (s2 >= (LatW + 1)'(LatPer)) ? LatW'(s2 - (LatW + 1)'(LatPer)) : LatW'(s2);
    endfunction

    function automatic t_pos next_pos(input t_pos p);
        t_pos           q;
        logic [ModW:0]  s;
        s = {p.m, p.f[15]};
        q.m = (s >= (ModW + 1)'(LatPer)) ? ModW'(s - (ModW + 1)'(LatPer)) : ModW'(s);
        q.z = p.z & ~p.f[15];
        q.f = {p.f[14:0], 1'b0};
        return q;
    endfunction

    always_comb begin
        lat_coords(i_in.px, w_lx);
        lat_coords(i_in.py, w_ly);
        n_sd0.valid  = i_in.valid;
        n_sd0.sum    = i_in.sum;
        n_sd0.amp    = i_in.amp;
        n_sd0.amp_nx = AmpW'((33'(i_in.amp) * 33'(i_pers)) >> 16);
        n_sd0.px     = next_pos(i_in.px);
        n_sd0.py     = next_pos(i_in.py);
        n_sd0.wx     = CosLut[i_in.px.f[15 -: CosBits]];
        n_sd0.wy     = CosLut[i_in.py.f[15 -: CosBits]];
    end

    for (genvar a = 0; a < 4; a++) begin : g_row
        for (genvar b = 0; b < 4; b++) begin : g_col
            vno_hash u_hash (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_lx  (w_lx[a]),
                .i_ly  (w_ly[b]),
                .o_g   (w_g[a][b])
            );
        end
    end

    assign w_act = {1'b0, i_idx} < (IdxW + 1)'(i_cnt > CntW'(MaxOct) ? CntW'(MaxOct) : i_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SdN; k++) begin
                r_sd[k] <= '0;
            end
            r_out <= '0;
        end else if (i_en) begin
            r_sd[0] <= n_sd0;
            for (int k = 1; k < SdN; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_out.valid <= r_sd[SdN-1].valid;
            r_out.sum   <= r_sd[SdN-1].sum + (w_act ? SumW'(r_ct) : '0);
            r_out.amp   <= r_sd[SdN-1].amp_nx;
            r_out.px    <= r_sd[SdN-1].px;
            r_out.py    <= r_sd[SdN-1].py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ci = 0; ci < 2; ci++) begin
                for (int cj = 0; cj < 2; cj++) begin
                    r_cor[ci][cj] <= SmW'(w_g[ci][cj]) + SmW'(w_g[ci+2][cj])
                                   + SmW'(w_g[ci][cj+2]) + SmW'(w_g[ci+2][cj+2]);
                    r_sid[ci][cj] <= SmW'(w_g[ci][cj+1]) + SmW'(w_g[ci+2][cj+1])
                                   + SmW'(w_g[ci+1][cj]) + SmW'(w_g[ci+1][cj+2]);
                    r_cen[ci][cj] <= SmW'(w_g[ci+1][cj+1]);
                    r_s[ci][cj]   <= r_cor[ci][cj] + (r_sid[ci][cj] <<< 1)
                                   + (r_cen[ci][cj] <<< 2);
                end
            end
            for (int j = 0; j < 2; j++) begin
                r_pa[j] <= PrW'(r_s[0][j]) * PrW'($signed({1'b0, 17'd65536 - 17'(r_sd[6].wx)}));
                r_pb[j] <= PrW'(r_s[1][j]) * PrW'($signed({2'b0, r_sd[6].wx}));
                r_r[j]  <= SmW'((r_pa[j] + r_pb[j]) >>> 16);
            end
            r_qa <= PrW'(r_r[0]) * PrW'($signed({1'b0, 17'd65536 - 17'(r_sd[8].wy)}));
            r_qb <= PrW'(r_r[1]) * PrW'($signed({2'b0, r_sd[8].wy}));
            r_rr <= SmW'((r_qa + r_qb) >>> 16);
            r_ct <= CtW'(r_rr) * CtW'($signed({1'b0, r_sd[10].amp}));
        end
    end

    assign o_out = r_out;

endmodule

FILE: design/vno_chk.sv
// ============================================================================
// Value noise port checker
// Watches the stream and register ports of the top level over time.
// ============================================================================
module vno_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("Input ready does not follow the output stall.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output transfer changed.");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("Register port not ready.");

endmodule

bind value_noise_2d_octaves_top vno_chk u_vno_chk (.*);
